// File: hdl/bmff_pkg.sv
// Shared types and constants for the top-level box walk.
// Holds the walk phases, result struct, verdict codes and known box types.
// No dependencies.
package bmff_pkg;

	localparam int KNOWN_TYPE_COUNT = 19;

	localparam logic [31:0] BOX_TYPE_TAB [KNOWN_TYPE_COUNT] = '{
		32'h66747970, 32'h6D6F6F76, 32'h6D646174, 32'h6D657461, 32'h66726565,
		32'h736B6970, 32'h75647461, 32'h73696E66, 32'h73636869, 32'h6D766864,
		32'h746B6864, 32'h7374626C, 32'h64696E66, 32'h736D6864, 32'h766D6864,
		32'h686D6864, 32'h6E6D6864, 32'h696C7374, 32'h75756964
	};

	localparam logic [1:0] VERDICT_REJECT   = 2'd0;
	localparam logic [1:0] VERDICT_CONTAINER = 2'd1;
	localparam logic [1:0] VERDICT_VERIFIED = 2'd2;

	localparam logic [3:0] KNOWN_MAX = 4'd15;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_EXTSIZE = 3'd1,
		PH_BODY    = 3'd2,
		PH_STOPPED = 3'd3,
		PH_UNKNOWN = 3'd4
	} bmff_phase_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [63:0] file_size;
		logic [3:0]  known_boxes_seen;
	} bmff_res_t;

	function automatic logic is_known_type(input logic [31:0] t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < KNOWN_TYPE_COUNT; i++) begin
			if (BOX_TYPE_TAB[i] == t) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// File: hdl/bmff_if.sv
// Channel interfaces for the box walk: byte input and result output.
// Valid/ready handshake; no dependencies.
interface bmff_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface bmff_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [63:0] file_size;
	logic [3:0]  known_boxes_seen;

	modport source(output valid, output verdict, output file_size,
		output known_boxes_seen, input ready);
	modport sink(input valid, input verdict, input file_size,
		input known_boxes_seen, output ready);
endinterface

// File: hdl/bmff_walk.sv
// Walk state for top-level boxes: header decode, box end tracking, counting.
// Computes the result for the byte in flight. Depends on bmff_pkg.
module bmff_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [3:0]          min_known,
	output bmff_pkg::bmff_res_t res
);

	bmff_pkg::bmff_phase_t phase_q, phase_n;
	logic [63:0] pos_q, start_q, start_n, pend_q, pend_n, total_q, total_n;
	logic [63:0] ext_q, ext_n, pos1, len, sum;
	logic [31:0] size_q, size_n, type_q, type_n;
	logic        pknown_q, pknown_n, open, hit, short_buf;
	logic [3:0]  cnt_q, cnt_n, hcnt_q, hcnt_n;

	always_comb begin
		phase_n  = phase_q;
		size_n   = size_q;
		type_n   = type_q;
		ext_n    = ext_q;
		pknown_n = pknown_q;
		start_n  = start_q;
		pend_n   = pend_q;
		total_n  = total_q;
		cnt_n    = cnt_q;
		hcnt_n   = hcnt_q + 4'd1;
		open     = 1'b0;
		len      = '0;
		pos1     = pos_q + 64'd1;
		case (phase_q)
			bmff_pkg::PH_HEADER: begin
				if (hcnt_q < 4'd4) begin
					size_n = {size_q[23:0], data_byte};
				end else begin
					type_n = {type_q[23:0], data_byte};
				end
				if (hcnt_q == 4'd7) begin
					pknown_n = bmff_pkg::is_known_type(type_n);
					if (size_n == 32'd1) begin
						ext_n   = '0;
						phase_n = bmff_pkg::PH_EXTSIZE;
					end else if (size_n == 32'd0) begin
						phase_n = bmff_pkg::PH_UNKNOWN;
					end else if (size_n < 32'd8) begin
						phase_n = bmff_pkg::PH_STOPPED;
					end else begin
						open = 1'b1;
						len  = {32'd0, size_n};
					end
				end
			end
			bmff_pkg::PH_EXTSIZE: begin
				ext_n = {ext_q[55:0], data_byte};
				if (hcnt_q == 4'd15) begin
					if (ext_n < 64'd16) begin
						phase_n = bmff_pkg::PH_STOPPED;
					end else begin
						open = 1'b1;
						len  = ext_n;
					end
				end
			end
			default: begin
			end
		endcase
		sum = start_q + len;
		if (open) begin
			total_n = sum;
			pend_n  = sum;
			phase_n = bmff_pkg::PH_BODY;
			hit     = (len == {60'd0, hcnt_q} + 64'd1);
		end else begin
			hit = (phase_q == bmff_pkg::PH_BODY) && (pos1 == pend_q);
		end
		if (hit) begin
			if (pknown_n && cnt_q < bmff_pkg::KNOWN_MAX) begin
				cnt_n = cnt_q + 4'd1;
			end
			start_n = pend_n;
			phase_n = bmff_pkg::PH_HEADER;
			hcnt_n  = '0;
		end
	end

	always_comb begin
		short_buf = (pos1 < 64'd8);
		if (short_buf) begin
			res.verdict          = bmff_pkg::VERDICT_REJECT;
			res.file_size        = '0;
			res.known_boxes_seen = '0;
		end else begin
			res.verdict = (cnt_n >= min_known) ? bmff_pkg::VERDICT_VERIFIED
				: bmff_pkg::VERDICT_CONTAINER;
			res.file_size        = (phase_n == bmff_pkg::PH_UNKNOWN) ? 64'd0 : total_n;
			res.known_boxes_seen = cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bmff_pkg::PH_HEADER;
			pos_q    <= '0;
			start_q  <= '0;
			size_q   <= '0;
			type_q   <= '0;
			ext_q    <= '0;
			pend_q   <= '0;
			pknown_q <= 1'b0;
			cnt_q    <= '0;
			total_q  <= '0;
			hcnt_q   <= '0;
		end else if (step && last_byte) begin
			phase_q  <= bmff_pkg::PH_HEADER;
			pos_q    <= '0;
			start_q  <= '0;
			size_q   <= '0;
			type_q   <= '0;
			ext_q    <= '0;
			pend_q   <= '0;
			pknown_q <= 1'b0;
			cnt_q    <= '0;
			total_q  <= '0;
			hcnt_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			pos_q    <= pos1;
			start_q  <= start_n;
			size_q   <= size_n;
			type_q   <= type_n;
			ext_q    <= ext_n;
			pend_q   <= pend_n;
			pknown_q <= pknown_n;
			cnt_q    <= cnt_n;
			total_q  <= total_n;
			hcnt_q   <= hcnt_n;
		end
	end

endmodule

// File: hdl/bmff_result.sv
// Result register for the box walk output channel.
// Loads on the final byte and holds until transfer. Depends on bmff_pkg, bmff_if.
module bmff_result (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bmff_pkg::bmff_res_t res,
	output logic                space,
	bmff_out_if.source          dst
);

	logic                vld_q;
	bmff_pkg::bmff_res_t res_q;

	assign space = !vld_q || dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (dst.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign dst.valid            = vld_q;
	assign dst.verdict          = res_q.verdict;
	assign dst.file_size        = res_q.file_size;
	assign dst.known_boxes_seen = res_q.known_boxes_seen;

endmodule

// File: hdl/bmff_box_walk_sizer.sv
// Top level of the ISO BMFF top-level box walk and file sizer.
// Uses bmff_pkg, bmff_if, bmff_walk and bmff_result.
//
// channel  dir  payload                                   transfer
// bytes    in   data_byte[7:0], last_byte                  valid && ready
// results  out  verdict[1:0], file_size[63:0], known[3:0]  valid && ready
// cfg      in   cfg_wdata[3:0] (min_known_boxes)           cfg_we
//
// One byte per cycle; the walk state updates in the cycle of the transfer.
// The result is registered at the final byte's transfer and offered from the next cycle.
// bytes.ready drops only while a result waits and results.ready is low.
// arst_n clears the walk and the result valid flag and sets min_known_boxes to 2.
module bmff_box_walk_sizer (
	input  logic       clk,
	input  logic       arst_n,
	bmff_in_if.sink    bytes,
	bmff_out_if.source results,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata
);

	logic [3:0]          min_q;
	logic                step, space;
	bmff_pkg::bmff_res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 4'd2;
		end else if (cfg_we) begin
			min_q <= cfg_wdata;
		end
	end

	assign bytes.ready = space;
	assign step        = bytes.valid && space;

	bmff_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (bytes.data_byte),
		.last_byte (bytes.last_byte),
		.min_known (min_q),
		.res       (res)
	);

	bmff_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && bytes.last_byte),
		.res    (res),
		.space  (space),
		.dst    (results)
	);

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		bytes.valid && bytes.ready && bytes.last_byte |=> results.valid)
		else $error("final byte transfer did not produce a result");

	a_reject_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.verdict == bmff_pkg::VERDICT_REJECT
		|-> results.file_size == 64'd0 && results.known_boxes_seen == 4'd0)
		else $error("reject result carries nonzero fields");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> bytes.ready)
		else $error("input stalled with no result waiting");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.verdict == bmff_pkg::VERDICT_REJECT
			|| results.verdict == bmff_pkg::VERDICT_CONTAINER
			|| results.verdict == bmff_pkg::VERDICT_VERIFIED))
		else $error("undefined verdict code");

endmodule
